// File: design/v210_video_unpacker_defines.svh
// Assertion macros for the v210 unpacker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef V210_VIDEO_UNPACKER_DEFINES_SVH
`define V210_VIDEO_UNPACKER_DEFINES_SVH
`ifndef ASSERT_OFF
`define V210U_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("v210 unpacker: implication check failed");
`define V210U_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("v210 unpacker: next-cycle check failed");
`else
`define V210U_ASSERT_IMP(label, clk, rst, ante, cons)
`define V210U_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/v210u_pkg.sv
// Shared types, constants and helper functions of the v210 unpacker.
// No dependencies; used by the stream interfaces and the top level.
package v210u_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_ROW_WORDS = 4096;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int DIM_W         = 13;
   localparam int CSR_ADDR_W    = 4;

   localparam logic [9:0] SAMPLE_MASK = 10'h3FF;
   localparam logic [9:0] PAD_LUMA    = 10'd64;
   localparam logic [9:0] PAD_CHROMA  = 10'd512;

   typedef logic [31:0]      word_type;
   typedef logic [29:0]      held_type;
   typedef logic [9:0]       sample_type;
   typedef logic [DIM_W-1:0] dim_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_ROW_WORDS    = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // Clamp to the upper limit.
   function automatic dim_type clamp_max(input dim_type v);
      clamp_max = (v > dim_type'(MAX_WIDTH)) ? dim_type'(MAX_WIDTH) : v;
   endfunction

   // Zero means one, and values are capped at the given limit.
   function automatic dim_type clamp_one(input dim_type v, input dim_type limit);
      if (v == '0) begin
         clamp_one = dim_type'(1);
      end else if (v > limit) begin
         clamp_one = limit;
      end else begin
         clamp_one = v;
      end
   endfunction

   // Division by six through a reciprocal; exact for values up to 4096.
   function automatic logic [9:0] div_by_six(input dim_type v);
      logic [26:0] prod;
      prod = {14'd0, v} * 27'd10923;
      div_by_six = prod[25:16];
   endfunction

endpackage

// File: design/v210u_req_if.sv
// Input word stream of the v210 unpacker: valid/ready plus one packed word.
// Depends on v210u_pkg for the payload type.
interface v210u_req_if;
   import v210u_pkg::*;

   logic     valid;
   logic     ready;
   word_type packed_word;

   modport source (output valid, output packed_word, input ready);
   modport sink   (input valid, input packed_word, output ready);
endinterface

// File: design/v210u_rsp_if.sv
// Pixel stream of the v210 unpacker: valid/ready plus one pixel and its flags.
// Depends on v210u_pkg for the sample type.
interface v210u_rsp_if;
   import v210u_pkg::*;

   logic       valid;
   logic       ready;
   sample_type luma;
   sample_type chroma_blue;
   sample_type chroma_red;
   logic       row_end;
   logic       frame_end;
   logic       run_last;

   modport source (output valid, output luma, output chroma_blue, output chroma_red,
                   output row_end, output frame_end, output run_last, input ready);
   modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                   input row_end, input frame_end, input run_last, output ready);
endinterface

// File: design/v210_video_unpacker.sv
// v210 10-bit 4:2:2 unpacker top level: APB register file, group decoder and pixel serializer.
// Depends on v210u_pkg, v210u_req_if, v210u_rsp_if and v210_video_unpacker_defines.svh.
// The pixels of a group pass through the burst register and then the output register.
// Throughput: one pixel per cycle while rsp.ready holds; a complete group of four words
// gives six to eleven pixels, so the single-pixel output port sets the sustained rate.
// Words that give no pixel are taken every cycle, also while earlier pixels are being sent.
// Reset (synchronous, active high) restores the default 1920x1080 format, stride 1280.
`include "v210_video_unpacker_defines.svh"

module v210_video_unpacker (
   input  logic                               clock,
   input  logic                               reset,
   v210u_req_if.sink                          req,
   v210u_rsp_if.source                        rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [v210u_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import v210u_pkg::*;

   // Configuration registers.
   dim_type       frame_width_ff, frame_height_ff, row_words_ff;
   csr_index_type csr_index;
   logic          csr_write;

   // Scan state.
   held_type    held_ff [3];
   logic [1:0]  phase_ff, phase_in;
   logic [11:0] wir_ff, wir_in;
   dim_type     col_ff, col_in;
   logic [11:0] row_ff, row_in;

   // Burst holding the pixels of one group while they are sent.
   logic        burst_valid_ff, burst_valid_in;
   held_type    bw_ff [4];
   logic        bpad_ff;
   logic [3:0]  bcnt_ff;
   logic [3:0]  bk_ff, bk_in;
   dim_type     bstart_ff;
   dim_type     bwidth_ff;
   logic        blast_ff;

   // Output register.
   logic       rsp_valid_ff;
   sample_type luma_ff, cb_ff, cr_ff;
   logic       row_end_ff, frame_end_ff, run_last_ff;

   // Decode of the current word.
   dim_type     eff_width, eff_height, eff_rw;
   logic [9:0]  groups;
   logic [2:0]  rem;
   logic [9:0]  grp;
   logic [3:0]  n_now;
   logic        accept, load_burst, out_load, burst_done;
   logic [12:0] wir_inc, row_inc;

   // Serializer selection.
   logic [2:0]  pix_idx;
   sample_type  sel_y, sel_cb, sel_cr;
   logic [13:0] sel_col;
   logic        sel_row_end;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= dim_type'(1920);
         frame_height_ff <= dim_type'(1080);
         row_words_ff    <= dim_type'(1280);
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[DIM_W-1:0];
            CSR_ROW_WORDS:    row_words_ff    <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_FRAME_WIDTH:  csr_prdata = {19'd0, frame_width_ff};
         CSR_FRAME_HEIGHT: csr_prdata = {19'd0, frame_height_ff};
         CSR_ROW_WORDS:    csr_prdata = {19'd0, row_words_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- word decode ----------------
   assign eff_width  = clamp_max(frame_width_ff);
   assign eff_height = clamp_one(frame_height_ff, dim_type'(HEIGHT_LIMIT));
   assign eff_rw     = clamp_one(row_words_ff, dim_type'(MAX_ROW_WORDS));
   assign groups     = div_by_six(eff_width);
   assign rem        = 3'(eff_width - dim_type'({groups, 2'b00} + {1'b0, groups, 1'b0}));
   assign grp        = wir_ff[11:2];

   always_comb begin
      n_now = 4'd0;
      if (grp < groups) begin
         if (phase_ff == 2'd3) begin
            n_now = (grp + 10'd1 == groups) ? 4'd6 + {1'b0, rem} : 4'd6;
         end
      end else if (groups == '0 && wir_ff == '0) begin
         n_now = {1'b0, rem};
      end
   end

   assign out_load   = burst_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign burst_done = out_load && (bk_ff + 4'd1 == bcnt_ff);
   assign req.ready  = !burst_valid_ff || burst_done || (n_now == 4'd0);
   assign accept     = req.valid && req.ready;
   assign load_burst = accept && (n_now != 4'd0);

   assign wir_inc = {1'b0, wir_ff} + 13'd1;
   assign row_inc = {1'b0, row_ff} + 13'd1;

   always_comb begin
      wir_in   = wir_ff;
      phase_in = phase_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (wir_inc >= eff_rw) begin
            wir_in   = '0;
            phase_in = '0;
            col_in   = '0;
            row_in   = (row_inc >= eff_height) ? '0 : row_inc[11:0];
         end else begin
            wir_in   = wir_inc[11:0];
            phase_in = phase_ff + 2'd1;
            col_in   = col_ff + dim_type'(n_now);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wir_ff   <= '0;
         phase_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         wir_ff   <= wir_in;
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // The first three words of a group are kept; stride padding is dropped.
   always_ff @(posedge clock) begin
      if (accept && grp < groups && phase_ff != 2'd3) begin
         held_ff[phase_ff] <= req.packed_word[29:0];
      end
   end

   // ---------------- burst register ----------------
   always_comb begin
      burst_valid_in = burst_valid_ff;
      bk_in          = bk_ff;
      if (load_burst) begin
         burst_valid_in = 1'b1;
         bk_in          = '0;
      end else if (burst_done) begin
         burst_valid_in = 1'b0;
      end else if (out_load) begin
         bk_in = bk_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_valid_ff <= 1'b0;
         bk_ff          <= '0;
      end else begin
         burst_valid_ff <= burst_valid_in;
         bk_ff          <= bk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_burst) begin
         bw_ff[0]  <= held_ff[0];
         bw_ff[1]  <= held_ff[1];
         bw_ff[2]  <= held_ff[2];
         bw_ff[3]  <= req.packed_word[29:0];
         bpad_ff   <= (groups == '0);
         bcnt_ff   <= n_now;
         bstart_ff <= col_ff;
         bwidth_ff <= eff_width;
         blast_ff  <= (row_inc == eff_height);
      end
   end

   // ---------------- pixel serializer ----------------
   // Pixels past the sixth repeat the last decoded pixel of the group.
   assign pix_idx = (bk_ff > 4'd5) ? 3'd5 : bk_ff[2:0];

   always_comb begin
      case (pix_idx)
         3'd0:    sel_y = bw_ff[0][19:10];
         3'd1:    sel_y = bw_ff[1][9:0];
         3'd2:    sel_y = bw_ff[1][29:20];
         3'd3:    sel_y = bw_ff[2][19:10];
         3'd4:    sel_y = bw_ff[3][9:0];
         default: sel_y = bw_ff[3][29:20];
      endcase
      case (pix_idx[2:1])
         2'd0: begin
            sel_cb = bw_ff[0][9:0];
            sel_cr = bw_ff[0][29:20];
         end
         2'd1: begin
            sel_cb = bw_ff[1][19:10];
            sel_cr = bw_ff[2][9:0];
         end
         default: begin
            sel_cb = bw_ff[2][29:20];
            sel_cr = bw_ff[3][19:10];
         end
      endcase
      if (bpad_ff) begin
         sel_y  = PAD_LUMA;
         sel_cb = PAD_CHROMA;
         sel_cr = PAD_CHROMA;
      end
   end

   assign sel_col     = {1'b0, bstart_ff} + {10'd0, bk_ff} + 14'd1;
   assign sel_row_end = (sel_col == {1'b0, bwidth_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         luma_ff      <= sel_y & SAMPLE_MASK;
         cb_ff        <= sel_cb & SAMPLE_MASK;
         cr_ff        <= sel_cr & SAMPLE_MASK;
         row_end_ff   <= sel_row_end;
         frame_end_ff <= sel_row_end && blast_ff;
         run_last_ff  <= (bk_ff + 4'd1 == bcnt_ff);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.luma        = luma_ff;
   assign rsp.chroma_blue = cb_ff;
   assign rsp.chroma_red  = cr_ff;
   assign rsp.row_end     = row_end_ff;
   assign rsp.frame_end   = frame_end_ff;
   assign rsp.run_last    = run_last_ff;

   // ---------------- assertions ----------------
   `V210U_ASSERT_IMP(a_burst_index, clock, reset, burst_valid_ff, bk_ff < bcnt_ff)
   `V210U_ASSERT_NXT(a_burst_load, clock, reset, load_burst, burst_valid_ff && bk_ff == 4'd0)
   `V210U_ASSERT_IMP(a_frame_row, clock, reset, rsp_valid_ff && frame_end_ff, row_end_ff)
   `V210U_ASSERT_IMP(a_burst_size, clock, reset, burst_valid_ff, bcnt_ff != 4'd0 && bcnt_ff <= 4'd11)

endmodule
